### hw/rtl/ks2s_pkg.sv
// shared types and constants for the two-sample ks statistic core
package ks2s_pkg;

    localparam int VALUE_W      = 16;
    localparam int COEF_W       = 16;
    localparam int DIST_W       = 17;
    localparam int ERR_W        = 2;
    localparam int Q_FRAC       = 16;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [COEF_W-1:0] COEF_RESET = 16'd18496;
    localparam int unsigned       COEF_SCALE = 10000;
    localparam logic [DIST_W-1:0] DIST_ONE   = 17'h10000;

    localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_second;
        logic                      is_last;
    } item_t;

    typedef enum logic [3:0] {
        EV_IDLE,
        EV_CHECK,
        EV_ZRD,
        EV_ZLATCH,
        EV_SCAN,
        EV_GAP,
        EV_MAX,
        EV_MUL1,
        EV_MUL2,
        EV_CMP,
        EV_WAITDIV,
        EV_EMIT
    } eval_state_t;

endpackage

### hw/rtl/ks2s_front.sv
// front end: takes input items, tags them and queues them for the back end
module ks2s_front
    import ks2s_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [VALUE_W-1:0] s_sample_value,
    input  logic                      s_from_second,
    input  logic                      s_last,
    output logic                      pop_valid,
    input  logic                      pop_ready,
    output item_t                     pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    item_t              in_item;
    logic               push, pop;

    // tag the item with its sample and end marker
    always_comb begin
        in_item.value     = s_sample_value;
        in_item.is_second = s_from_second;
        in_item.is_last   = s_last;
    end

    assign s_ready   = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        fill_next = fill_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### hw/rtl/ks2s_div.sv
// radix-2 restoring divider giving floor(dividend * 2^16 / divisor), dividend <= divisor
module ks2s_div
    import ks2s_pkg::*;
#(
    parameter int PW = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PW-1:0]     dividend,
    input  logic [PW-1:0]     divisor,
    output logic              busy,
    output logic [DIST_W-1:0] quotient
);

    localparam int CNT_W = $clog2(Q_FRAC + 1);

    logic [PW-1:0]     rem_reg, rem_next;
    logic [PW-1:0]     dsr_reg, dsr_next;
    logic [DIST_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [PW:0]       shifted, trial;
    logic              fits, top_bit;

    always_comb begin
        shifted   = {rem_reg, 1'b0};
        trial     = shifted - {1'b0, dsr_reg};
        fits      = (shifted >= {1'b0, dsr_reg});
        top_bit   = (dividend >= divisor);
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            // integer bit: set when dividend >= divisor, so only when they are equal
            dsr_next  = divisor;
            rem_next  = top_bit ? (dividend - divisor) : dividend;
            quo_next  = {{(DIST_W-1){1'b0}}, top_bit};
            cnt_next  = CNT_W'(Q_FRAC);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? trial[PW-1:0] : shifted[PW-1:0];
            quo_next  = {quo_reg[DIST_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### hw/rtl/ks2s_eval.sv
// back end: sample stores, ecdf gap search, divide and critical test, result register
module ks2s_eval
    import ks2s_pkg::*;
#(
    parameter int SAMPLE_CAPACITY = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  item_t             pop_item,
    input  logic [COEF_W-1:0] coef,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DIST_W-1:0] m_distance_q16,
    output logic              m_reject,
    output logic [ERR_W-1:0]  m_error_code
);

    localparam int CW = $clog2(SAMPLE_CAPACITY + 1);
    localparam int AW = $clog2(SAMPLE_CAPACITY);
    localparam int TW = CW + 1;
    localparam int PW = 2 * CW;
    localparam int SW = 2 * PW;
    localparam int KW = COEF_W + TW;
    localparam int LW = 2 * PW + COEF_W;

    logic signed [VALUE_W-1:0] first_mem  [SAMPLE_CAPACITY];
    logic signed [VALUE_W-1:0] second_mem [SAMPLE_CAPACITY];

    eval_state_t state_reg, state_next;
    logic [CW-1:0] n1_reg, n2_reg;
    logic          ovf_reg;
    logic          m_valid_reg;

    logic signed [VALUE_W-1:0] rd1_reg, rd2_reg, z_reg;
    logic [TW-1:0]     j_reg;
    logic [CW-1:0]     i_reg, c1_reg, c2_reg;
    logic [PW-1:0]     a_reg, b_reg, best_reg, prod_reg;
    logic [SW-1:0]     sq_reg;
    logic [KW-1:0]     t_reg;
    logic [LW-1:0]     lhs_reg, rhs_reg;
    logic [DIST_W-1:0] res_dist_reg, m_dist_reg;
    logic              res_rej_reg, m_rej_reg;
    logic [ERR_W-1:0]  res_err_reg, m_err_reg;

    logic [AW-1:0]     rd_addr1, rd_addr2;
    logic              pop_fire, wr1, wr2, emit_load, div_start, div_busy;
    logic              n1_full, n2_full, j_first;
    logic [TW-1:0]     total, last_j, j_off;
    logic [CW-1:0]     max_n;
    logic [PW-1:0]     diff;
    logic [DIST_W-1:0] div_quo;

    assign n1_full  = (n1_reg == CW'(SAMPLE_CAPACITY));
    assign n2_full  = (n2_reg == CW'(SAMPLE_CAPACITY));
    assign pop_fire = pop_valid && pop_ready;
    assign wr1      = pop_fire && !pop_item.is_second && !n1_full;
    assign wr2      = pop_fire && pop_item.is_second && !n2_full;
    assign total    = TW'(n1_reg) + TW'(n2_reg);
    assign last_j   = total - 1'b1;
    assign j_off    = j_reg - TW'(n1_reg);
    assign j_first  = (j_reg < TW'(n1_reg));
    assign max_n    = (n1_reg > n2_reg) ? n1_reg : n2_reg;
    assign diff     = (a_reg >= b_reg) ? (a_reg - b_reg) : (b_reg - a_reg);

    ks2s_div #(
        .PW (PW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (best_reg),
        .divisor  (prod_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            EV_IDLE: begin
                if (pop_fire && pop_item.is_last) state_next = EV_CHECK;
            end
            EV_CHECK: begin
                if (ovf_reg || n1_reg == '0 || n2_reg == '0) state_next = EV_EMIT;
                else state_next = EV_ZRD;
            end
            EV_ZRD:    state_next = EV_ZLATCH;
            EV_ZLATCH: state_next = EV_SCAN;
            EV_SCAN: begin
                if (i_reg == max_n) state_next = EV_GAP;
            end
            EV_GAP: state_next = EV_MAX;
            EV_MAX: begin
                if (j_reg == last_j) state_next = EV_MUL1;
                else state_next = EV_ZRD;
            end
            EV_MUL1: state_next = EV_MUL2;
            EV_MUL2: state_next = EV_CMP;
            EV_CMP:  state_next = EV_WAITDIV;
            EV_WAITDIV: begin
                if (!div_busy) state_next = EV_EMIT;
            end
            EV_EMIT: begin
                if (emit_load) state_next = EV_IDLE;
            end
            default: state_next = EV_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        pop_ready = 1'b0;
        div_start = 1'b0;
        emit_load = 1'b0;
        rd_addr1  = i_reg[AW-1:0];
        rd_addr2  = i_reg[AW-1:0];
        case (state_reg)
            EV_IDLE: pop_ready = 1'b1;
            EV_ZRD: begin
                rd_addr1 = j_reg[AW-1:0];
                rd_addr2 = j_off[AW-1:0];
            end
            EV_MUL1: div_start = 1'b1;
            EV_EMIT: emit_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= EV_IDLE;
            n1_reg      <= '0;
            n2_reg      <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop_fire) begin
                if (pop_item.is_second) begin
                    if (n2_full) ovf_reg <= 1'b1;
                    else n2_reg <= n2_reg + 1'b1;
                end else begin
                    if (n1_full) ovf_reg <= 1'b1;
                    else n1_reg <= n1_reg + 1'b1;
                end
            end
            if (emit_load) begin
                n1_reg      <= '0;
                n2_reg      <= '0;
                ovf_reg     <= 1'b0;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // sample stores
    always_ff @(posedge aclk) begin
        if (wr1) first_mem[n1_reg[AW-1:0]] <= pop_item.value;
        if (wr2) second_mem[n2_reg[AW-1:0]] <= pop_item.value;
        rd1_reg <= first_mem[rd_addr1];
        rd2_reg <= second_mem[rd_addr2];
    end

    // evaluation datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            EV_CHECK: begin
                j_reg        <= '0;
                best_reg     <= '0;
                prod_reg     <= PW'(n1_reg) * PW'(n2_reg);
                res_dist_reg <= '0;
                res_rej_reg  <= 1'b0;
                res_err_reg  <= ovf_reg ? ERR_OVERFLOW : ERR_EMPTY;
            end
            EV_ZRD: begin
                i_reg  <= '0;
                c1_reg <= '0;
                c2_reg <= '0;
            end
            EV_ZLATCH: z_reg <= j_first ? rd1_reg : rd2_reg;
            EV_SCAN: begin
                // read data is registered, so it belongs to the previous address
                i_reg <= i_reg + 1'b1;
                if (i_reg != '0) begin
                    if (i_reg <= n1_reg && rd1_reg <= z_reg) c1_reg <= c1_reg + 1'b1;
                    if (i_reg <= n2_reg && rd2_reg <= z_reg) c2_reg <= c2_reg + 1'b1;
                end
            end
            EV_GAP: begin
                a_reg <= PW'(c1_reg) * PW'(n2_reg);
                b_reg <= PW'(c2_reg) * PW'(n1_reg);
            end
            EV_MAX: begin
                if (diff > best_reg) best_reg <= diff;
                j_reg <= j_reg + 1'b1;
            end
            EV_MUL1: begin
                sq_reg <= SW'(best_reg) * SW'(best_reg);
                t_reg  <= KW'(coef) * KW'(total);
            end
            EV_MUL2: begin
                lhs_reg <= LW'(sq_reg) * LW'(COEF_SCALE);
                rhs_reg <= LW'(t_reg) * LW'(prod_reg);
            end
            EV_CMP: res_rej_reg <= (lhs_reg > rhs_reg);
            EV_WAITDIV: begin
                if (!div_busy) begin
                    res_dist_reg <= div_quo;
                    res_err_reg  <= ERR_OK;
                end
            end
            default: ;
        endcase
        if (emit_load) begin
            m_dist_reg <= res_dist_reg;
            m_rej_reg  <= res_rej_reg;
            m_err_reg  <= res_err_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_distance_q16 = m_dist_reg;
    assign m_reject       = m_rej_reg;
    assign m_error_code   = m_err_reg;

endmodule

### hw/rtl/two_sample_ks_statistic_core.sv
// top level of the two-sample kolmogorov-smirnov statistic core
//
//  channel  | direction | handshake          | content
//  ---------+-----------+--------------------+------------------------------------------
//  s_       | in        | s_valid / s_ready  | sample_value, from_second, last
//  m_       | out       | m_valid / m_ready  | distance_q16, reject, error_code
//  cfg_     | in        | cfg_wr_en          | cfg_wr_data = critical_coef_sq
//
//  loading: one item per cycle while no evaluation runs; a two-entry queue feeds the back end
//  evaluation after the last item is paced by the single read port on each sample store
//  (one stored value from each store compared per cycle)
//  the serial divider (17 steps) overlaps the critical-value products
//  reset is synchronous and active low; it empties the queue, counts and result register
//  the result register holds until m_ready, while the queue keeps taking items
module two_sample_ks_statistic_core
    import ks2s_pkg::*;
#(
    parameter int SAMPLE_CAPACITY = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [VALUE_W-1:0] s_sample_value,
    input  logic                      s_from_second,
    input  logic                      s_last,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [DIST_W-1:0]         m_distance_q16,
    output logic                      m_reject,
    output logic [ERR_W-1:0]          m_error_code,
    input  logic                      cfg_wr_en,
    input  logic [COEF_W-1:0]         cfg_wr_data
);

    // critical coefficient squared, in units of 1/10000
    logic [COEF_W-1:0] coef_reg;

    // queued item between front and back
    logic  q_valid, q_ready;
    item_t q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= COEF_RESET;
        end else if (cfg_wr_en) begin
            coef_reg <= cfg_wr_data;
        end
    end

    // front: takes items and tags them by sample
    ks2s_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .s_from_second  (s_from_second),
        .s_last         (s_last),
        .pop_valid      (q_valid),
        .pop_ready      (q_ready),
        .pop_item       (q_item)
    );

    // back: stores samples, searches the largest ecdf gap, divides and tests
    ks2s_eval #(
        .SAMPLE_CAPACITY (SAMPLE_CAPACITY)
    ) u_eval (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (q_valid),
        .pop_ready      (q_ready),
        .pop_item       (q_item),
        .coef           (coef_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_distance_q16 (m_distance_q16),
        .m_reject       (m_reject),
        .m_error_code   (m_error_code)
    );

`ifndef SYNTH
    // an error result carries no distance and no rejection
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_error_code != ERR_OK)) |-> ((m_distance_q16 == '0) && !m_reject))
        else $error("error result with nonzero distance or reject");

    // the statistic never exceeds one
    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_error_code == ERR_OK)) |-> (m_distance_q16 <= DIST_ONE))
        else $error("distance above 1.0");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule

### test/testbench.sv
// self-checking testbench for the two-sample kolmogorov-smirnov statistic core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ks2s_pkg::*;

    localparam int SAMPLE_CAPACITY = 32;
    // worst evaluation: both stores full, one stored value from each store compared per cycle
    localparam int MAX_EVAL_CYCLES = 2 + 2 * SAMPLE_CAPACITY * (SAMPLE_CAPACITY + 5) + 18;
    localparam int WATCHDOG_LIMIT  = 4 * MAX_EVAL_CYCLES + 1000;
    // cycles to let queued non-last items settle before touching the coefficient
    localparam int SETTLE_CYCLES   = 64;
    localparam int DIRECTED_ROWS   = 23;
    localparam int RANDOM_ITEMS    = 425;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              reject;
        logic [ERR_W-1:0]  err;
    } ks_result_t;

    typedef enum bit [0:0] {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [VALUE_W-1:0] value;   // coefficient on a cfg row
        logic               second;
        logic               last;
        logic               typed;   // use the expectation typed in the row
        ks_result_t         want;
    } stim_row_t;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    localparam ks_result_t NO_RESULT = '0;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [VALUE_W-1:0] s_sample_value = '0;
    logic                      s_from_second = 1'b0;
    logic                      s_last = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [DIST_W-1:0]         m_distance_q16;
    logic                      m_reject;
    logic [ERR_W-1:0]          m_error_code;
    logic                      cfg_wr_en = 1'b0;
    logic [COEF_W-1:0]         cfg_wr_data = '0;

    // predictor state: its own copy of both sample stores and the coefficient
    logic signed [VALUE_W-1:0] first_vals  [SAMPLE_CAPACITY];
    logic signed [VALUE_W-1:0] second_vals [SAMPLE_CAPACITY];
    int                        first_n = 0;
    int                        second_n = 0;
    logic                      overflowed = 1'b0;
    logic [COEF_W-1:0]         coef_model = COEF_RESET;

    ks_result_t pending_results [$];
    ks_result_t arrived_want;
    int         fail_count = 0;
    int         items_sent = 0;
    int         burst_left = 0;
    int         idle_cycles = 0;
    int         rx_tick = 0;
    int         rx_left = 0;
    rx_mode_t   rx_mode = RX_ALWAYS;

    // directed part: extremes, both samples as last, ties, coefficient extremes
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // a lone item in either sample leaves the other one empty
        '{ROW_ITEM, 16'd100,  1'b0, 1'b1, 1'b1, '{17'd0, 1'b0, ERR_EMPTY}},
        '{ROW_ITEM, 16'hFFFB, 1'b1, 1'b1, 1'b1, '{17'd0, 1'b0, ERR_EMPTY}},
        // most negative against most positive: full separation, D = 1.0
        '{ROW_ITEM, 16'h8000, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 16'h7FFF, 1'b1, 1'b1, 1'b1, '{DIST_ONE, 1'b0, ERR_OK}},
        // identical samples give zero distance
        '{ROW_ITEM, 16'd7,    1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 16'd7,    1'b1, 1'b1, 1'b1, '{17'd0, 1'b0, ERR_OK}},
        // zero coefficient: any nonzero gap rejects
        '{ROW_CFG,  16'd0,    1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 16'd1,    1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 16'd2,    1'b1, 1'b1, 1'b1, '{DIST_ONE, 1'b1, ERR_OK}},
        // largest coefficient, reversed order of the extremes
        '{ROW_CFG,  16'hFFFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 16'h7FFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 16'h8000, 1'b1, 1'b1, 1'b1, '{DIST_ONE, 1'b0, ERR_OK}},
        '{ROW_CFG,  COEF_RESET, 1'b0, 1'b0, 1'b0, NO_RESULT},
        // ties within and across samples, last item in the first sample
        '{ROW_ITEM, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 16'd3,    1'b1, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 16'hFFFF, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 16'd0,    1'b1, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 16'h8000, 1'b0, 1'b1, 1'b0, NO_RESULT},
        // alternating bit patterns
        '{ROW_ITEM, 16'h5555, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 16'hAAAA, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 16'd0,    1'b1, 1'b0, 1'b0, NO_RESULT},
        '{ROW_ITEM, 16'h5555, 1'b0, 1'b1, 1'b0, NO_RESULT}
    };

    two_sample_ks_statistic_core #(
        .SAMPLE_CAPACITY (SAMPLE_CAPACITY)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .s_from_second  (s_from_second),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_distance_q16 (m_distance_q16),
        .m_reject       (m_reject),
        .m_error_code   (m_error_code),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // stores one item; on a last item works out the ks result and clears both samples
    function automatic bit predict_ks_result(input logic signed [VALUE_W-1:0] value,
                                             input logic second, input logic last,
                                             output ks_result_t res);
        longint unsigned best, gap, c1, c2, prod, lhs, rhs;
        logic signed [VALUE_W-1:0] z;
        int k, j;
        res = NO_RESULT;
        // a full store drops the item and flags the set
        if (second) begin
            if (second_n < SAMPLE_CAPACITY) begin
                second_vals[second_n] = value;
                second_n++;
            end else begin
                overflowed = 1'b1;
            end
        end else begin
            if (first_n < SAMPLE_CAPACITY) begin
                first_vals[first_n] = value;
                first_n++;
            end else begin
                overflowed = 1'b1;
            end
        end
        if (!last)
            return 1'b0;
        // overflow wins over an empty sample
        if (overflowed) begin
            res.err = ERR_OVERFLOW;
        end else if (first_n == 0 || second_n == 0) begin
            res.err = ERR_EMPTY;
        end else begin
            best = 0;
            for (k = 0; k < first_n + second_n; k++) begin
                z  = (k < first_n) ? first_vals[k] : second_vals[k - first_n];
                c1 = 0;
                c2 = 0;
                for (j = 0; j < first_n; j++)
                    if (first_vals[j] <= z) c1++;
                for (j = 0; j < second_n; j++)
                    if (second_vals[j] <= z) c2++;
                c1  = c1 * longint'(second_n);
                c2  = c2 * longint'(first_n);
                gap = (c1 > c2) ? c1 - c2 : c2 - c1;
                if (gap > best) best = gap;
            end
            prod = longint'(first_n) * longint'(second_n);
            res.distance = DIST_W'((best << Q_FRAC) / prod);
            // exact integer form of D > c * sqrt((n1+n2)/(n1*n2))
            lhs = best * best * COEF_SCALE;
            rhs = coef_model;
            rhs = rhs * longint'(first_n + second_n) * prod;
            res.reject = (lhs > rhs);
            res.err = ERR_OK;
        end
        first_n = 0;
        second_n = 0;
        overflowed = 1'b0;
        return 1'b1;
    endfunction

    // offers one item in the current burst, waits for the handshake, records the expectation
    task automatic send_item(input logic [VALUE_W-1:0] value, input logic second,
                             input logic last, input logic typed, input ks_result_t want);
        int gap;
        ks_result_t got;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_sample_value <= value;
        s_from_second  <= second;
        s_last         <= last;
        do
            @(posedge aclk);
        while (!s_ready);
        items_sent++;
        if (predict_ks_result(value, second, last, got))
            pending_results.push_back(typed ? want : got);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // coefficient writes only once the block has gone quiet
    task automatic write_coef(input logic [COEF_W-1:0] coef);
        s_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= coef;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        coef_model = coef;
    endtask

    // one complete data set: n1 first-sample and n2 second-sample items in random order
    // span 0 draws full-range values, otherwise a window of span+1 values that favours ties
    task automatic send_set(input int n1, input int n2, input int span);
        int rem1, rem2, base;
        logic second;
        logic [VALUE_W-1:0] value;
        rem1 = n1;
        rem2 = n2;
        base = $urandom_range(0, 65535);
        while (rem1 + rem2 > 0) begin
            second = (int'($urandom_range(1, rem1 + rem2)) > rem1);
            if (second)
                rem2--;
            else
                rem1--;
            if (span == 0)
                value = VALUE_W'($urandom_range(0, 65535));
            else
                value = VALUE_W'(base + int'($urandom_range(0, span)));
            send_item(value, second, (rem1 + rem2 == 0), 1'b0, NO_RESULT);
        end
    endtask

    initial begin
        int row, set_idx, pick, n1, n2, span;
        logic [COEF_W-1:0] coef;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (row = 0; row < DIRECTED_ROWS; row++) begin
            if (directed_rows[row].kind == ROW_CFG)
                write_coef(directed_rows[row].value);
            else
                send_item(directed_rows[row].value, directed_rows[row].second,
                          directed_rows[row].last, directed_rows[row].typed,
                          directed_rows[row].want);
        end

        // random data sets, mostly small and well formed
        set_idx = 0;
        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: span = 0;
                1: span = 3;
                2: span = 15;
                default: span = 255;
            endcase
            pick = $urandom_range(0, 99);
            if (set_idx == 4) begin
                // overflow with the other sample empty
                n1 = 33;
                n2 = 0;
            end else if (set_idx == 9) begin
                n1 = 3;
                n2 = 34;
            end else if (set_idx == 14) begin
                // both stores filled to capacity
                n1 = SAMPLE_CAPACITY;
                n2 = SAMPLE_CAPACITY;
            end else if (pick < 65) begin
                n1 = $urandom_range(1, 8);
                n2 = $urandom_range(1, 8);
            end else if (pick < 77) begin
                n1 = $urandom_range(1, 20);
                n2 = $urandom_range(9, 20);
            end else if (pick < 87) begin
                // one sample left empty
                if ($urandom_range(0, 1) == 0) begin
                    n1 = 0;
                    n2 = $urandom_range(1, 5);
                end else begin
                    n1 = $urandom_range(1, 5);
                    n2 = 0;
                end
            end else if (pick < 92) begin
                if ($urandom_range(0, 1) == 0) begin
                    n1 = SAMPLE_CAPACITY + 1;
                    n2 = $urandom_range(0, 4);
                end else begin
                    n1 = $urandom_range(0, 4);
                    n2 = SAMPLE_CAPACITY + 1;
                end
            end else begin
                n1 = 1;
                n2 = 1;
            end
            send_set(n1, n2, span);
            set_idx++;

            if (set_idx == 6 || $urandom_range(0, 9) == 0) begin
                // sender holds off until every result is back
                s_valid <= 1'b0;
                wait_drained();
            end else if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 4))
                    0: coef = '0;
                    1: coef = '1;
                    2: coef = COEF_RESET;
                    default: coef = COEF_W'($urandom_range(0, 65535));
                endcase
                write_coef(coef);
            end
        end

        s_valid <= 1'b0;
        wait_drained();
        // give a stray extra result time to show up
        repeat (MAX_EVAL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("two_sample_ks_statistic_core regression: pass");
        else
            $display("two_sample_ks_statistic_core regression: fail");
        $finish;
    end

    // result side stalls in modes that are redrawn at random whenever rx_left runs out
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(40, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS: m_ready <= 1'b1;
            RX_COIN:   m_ready <= ($urandom_range(0, 1) == 0);
            RX_SPARSE: m_ready <= (rx_tick % 7 == 0);
            default:   m_ready <= ($urandom_range(0, 5) != 0);
        endcase
    end

    // compare every accepted result against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error({"result item with nothing expected: ",
                        "distance_q16 %0d reject %0d error_code %0d"},
                       m_distance_q16, m_reject, m_error_code);
                fail_count++;
            end else begin
                arrived_want = pending_results.pop_front();
                if (m_distance_q16 !== arrived_want.distance) begin
                    $error("distance_q16 expected %0d actual %0d",
                           arrived_want.distance, m_distance_q16);
                    fail_count++;
                end
                if (m_reject !== arrived_want.reject) begin
                    $error("reject expected %0d actual %0d", arrived_want.reject, m_reject);
                    fail_count++;
                end
                if (m_error_code !== arrived_want.err) begin
                    $error("error_code expected %0d actual %0d",
                           arrived_want.err, m_error_code);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else if (aresetn)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("two_sample_ks_statistic_core regression: fail");
            $finish;
        end
    end

endmodule
